/* rtl/doppler_phase_rotator_macros.svh */
// doppler_phase_rotator_macros.svh: assertion macros shared by the rotator rtl
// expects signals clk and rst_n in the module that uses them
`ifndef DOPPLER_PHASE_ROTATOR_MACROS_SVH
`define DOPPLER_PHASE_ROTATOR_MACROS_SVH

// same-cycle implication, checked while out of reset
`define DPR_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rotator same-cycle check failed");

// next-cycle implication, checked while out of reset
`define DPR_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rotator next-cycle check failed");

`endif

/* rtl/dpr_pkg.sv */
// dpr_pkg: shared types, constants and the sine table builder for the rotator
// no dependencies
package dpr_pkg;

    // quarter-wave sine entries are q1.15 magnitudes, 0..32767
    localparam int unsigned TRIG_WIDTH  = 16;
    // fraction bits of the table and of the product rounding
    localparam int unsigned FRAC_BITS   = 15;
    // pi/2 in q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // register indexes of the configuration port
    localparam logic REG_PHASE_STEP = 1'b0;

    // quadrant of the phase word, top two bits
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // load strobes for the pipeline stages
    typedef struct packed {
        logic s1_load;
        logic s2_load;
        logic s3_load;
    } pipe_ctl_t;

    // one taylor step: term times theta^2, divided by the step's constant
    function automatic logic [63:0] taylor_term(input logic [63:0] term,
                                                input logic [63:0] th2,
                                                input int unsigned step);
        logic [63:0] prod;
        logic [63:0] res;
        prod = (term * th2) >> 30;
        case (step)
            1:       res = prod / 64'd6;
            2:       res = prod / 64'd20;
            3:       res = prod / 64'd42;
            4:       res = prod / 64'd72;
            5:       res = prod / 64'd110;
            6:       res = prod / 64'd156;
            default: res = prod / 64'd210;
        endcase
        return res;
    endfunction

    // sine entry k of a table with 2^aw steps over a quarter turn
    function automatic logic [TRIG_WIDTH-1:0] sine_entry(input int unsigned k,
                                                         input int unsigned aw);
        logic [63:0] theta;
        logic [63:0] th2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        theta = (64'(k) * HALF_PI_Q30) >> aw;
        th2   = (theta * theta) >> 30;
        term  = theta;
        sum   = theta;
        for (int unsigned n = 1; n <= 7; n++) begin
            term = taylor_term(term, th2, n);
            if (n % 2 == 1) begin
                sum = (term > sum) ? 64'd0 : sum - term;
            end
            else begin
                sum = sum + term;
            end
        end
        v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[TRIG_WIDTH-1:0];
    endfunction

endpackage

/* rtl/dpr_sine_rom.sv */
// dpr_sine_rom: quarter-wave sine table with two registered read ports
// depends on dpr_pkg
module dpr_sine_rom #(
    parameter int TABLE_ADDR_WIDTH = 10
) (
    input  logic                               clk,
    input  logic                               rd_en,
    input  logic [TABLE_ADDR_WIDTH:0]          addr_a,
    input  logic [TABLE_ADDR_WIDTH:0]          addr_b,
    output logic [dpr_pkg::TRIG_WIDTH-1:0]     data_a,
    output logic [dpr_pkg::TRIG_WIDTH-1:0]     data_b
);
    import dpr_pkg::*;

    localparam int DEPTH = (1 << TABLE_ADDR_WIDTH) + 1;

    typedef logic [TRIG_WIDTH-1:0] rom_t [DEPTH];

    // table contents fixed at elaboration
    function automatic rom_t build_rom();
        rom_t t;
        for (int i = 0; i < DEPTH; i++) begin
            t[i] = sine_entry(i, TABLE_ADDR_WIDTH);
        end
        return t;
    endfunction

    localparam rom_t ROM = build_rom();

    logic [TRIG_WIDTH-1:0] data_a_reg;
    logic [TRIG_WIDTH-1:0] data_b_reg;

    // registered reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            data_a_reg <= ROM[addr_a];
            data_b_reg <= ROM[addr_b];
        end
    end

    assign data_a = data_a_reg;
    assign data_b = data_b_reg;

endmodule

/* rtl/dpr_rotate.sv */
// dpr_rotate: quadrant fold, complex multiply, rounding and saturation stages
// depends on dpr_pkg
module dpr_rotate #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                clk,
    input  dpr_pkg::pipe_ctl_t                  ctl,
    input  logic [dpr_pkg::TRIG_WIDTH-1:0]      tbl_a,
    input  logic [dpr_pkg::TRIG_WIDTH-1:0]      tbl_b,
    input  logic [1:0]                          quad,
    input  logic signed [SAMPLE_WIDTH-1:0]      re,
    input  logic signed [SAMPLE_WIDTH-1:0]      im,
    input  logic                                last,
    output logic signed [SAMPLE_WIDTH-1:0]      rotated_re,
    output logic signed [SAMPLE_WIDTH-1:0]      rotated_im,
    output logic                                rotated_last
);
    import dpr_pkg::*;

    localparam int CW = TRIG_WIDTH + 1;           // signed sin/cos
    localparam int PW = SAMPLE_WIDTH + CW;        // one product
    localparam int SW = PW + 1;                   // sum of two products

    localparam logic signed [SW-1:0] RND_HALF = SW'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [SW-1:0] SAT_MAX  = SW'((1 << (SAMPLE_WIDTH - 1)) - 1);
    localparam logic signed [SW-1:0] SAT_MIN  = -SAT_MAX - SW'(1);

    logic signed [CW-1:0] pos_a;
    logic signed [CW-1:0] pos_b;
    logic signed [CW-1:0] sin_v;
    logic signed [CW-1:0] cos_v;

    logic signed [PW-1:0] re_c_reg;
    logic signed [PW-1:0] im_s_reg;
    logic signed [PW-1:0] re_s_reg;
    logic signed [PW-1:0] im_c_reg;
    logic                 last2_reg;

    logic signed [SW-1:0] sum_re;
    logic signed [SW-1:0] sum_im;
    logic signed [SAMPLE_WIDTH-1:0] re_next;
    logic signed [SAMPLE_WIDTH-1:0] im_next;
    logic signed [SAMPLE_WIDTH-1:0] re_out_reg;
    logic signed [SAMPLE_WIDTH-1:0] im_out_reg;
    logic                           last_out_reg;

    // round half up by the fraction bits, then clamp to the sample range
    function automatic logic signed [SAMPLE_WIDTH-1:0] round_sat(
        input logic signed [SW-1:0] v);
        logic signed [SW-1:0] r;
        r = (v + RND_HALF) >>> FRAC_BITS;
        if (r > SAT_MAX) begin
            r = SAT_MAX;
        end
        else if (r < SAT_MIN) begin
            r = SAT_MIN;
        end
        return r[SAMPLE_WIDTH-1:0];
    endfunction

    // fold the quarter-wave entries into sin and cos by quadrant
    always_comb
    begin
        pos_a = signed'({1'b0, tbl_a});
        pos_b = signed'({1'b0, tbl_b});
        case (quad)
            QUAD_0:
            begin
                sin_v = pos_a;
                cos_v = pos_b;
            end
            QUAD_1:
            begin
                sin_v = pos_b;
                cos_v = -pos_a;
            end
            QUAD_2:
            begin
                sin_v = -pos_a;
                cos_v = -pos_b;
            end
            default:
            begin
                sin_v = -pos_b;
                cos_v = pos_a;
            end
        endcase
    end

    // product stage
    always_ff @(posedge clk)
    begin
        if (ctl.s2_load)
        begin
            re_c_reg  <= PW'(re) * PW'(cos_v);
            im_s_reg  <= PW'(im) * PW'(sin_v);
            re_s_reg  <= PW'(re) * PW'(sin_v);
            im_c_reg  <= PW'(im) * PW'(cos_v);
            last2_reg <= last;
        end
    end

    // sums and rounding
    always_comb
    begin
        sum_re  = SW'(re_c_reg) - SW'(im_s_reg);
        sum_im  = SW'(re_s_reg) + SW'(im_c_reg);
        re_next = round_sat(sum_re);
        im_next = round_sat(sum_im);
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (ctl.s3_load)
        begin
            re_out_reg   <= re_next;
            im_out_reg   <= im_next;
            last_out_reg <= last2_reg;
        end
    end

    assign rotated_re   = re_out_reg;
    assign rotated_im   = im_out_reg;
    assign rotated_last = last_out_reg;

endmodule

/* rtl/doppler_phase_rotator.sv */
// doppler_phase_rotator: top level, phase accumulator, config port, pipeline control
// depends on dpr_pkg, dpr_sine_rom, dpr_rotate, doppler_phase_rotator_macros.svh
//
//  channel   direction  handshake                    payload
//  sample    in         sample_valid / sample_stall  sample_re, sample_im, sample_last
//  rotated   out        rotated_valid / rotated_stall rotated_re, rotated_im, rotated_last
//  config    in         apb psel/penable/pwrite      paddr, pwdata, prdata
//
// one beat per clock sustained while rotated_stall is low; the result is registered through
// the input register, sine table read, products and round/saturate result register
// stages advance independently, so bubbles close up under a stalled output
// sample_stall rises only when all four stages hold beats and rotated_stall is high
// reset clears the stage valids, the phase accumulator and phase_step
`include "doppler_phase_rotator_macros.svh"

module doppler_phase_rotator #(
    parameter int SAMPLE_WIDTH     = 16,
    parameter int PHASE_WIDTH      = 32,
    parameter int TABLE_ADDR_WIDTH = 10
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // sample channel
    input  logic                           sample_valid,
    output logic                           sample_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_re,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_im,
    input  logic                           sample_last,
    // rotated channel
    output logic                           rotated_valid,
    input  logic                           rotated_stall,
    output logic signed [SAMPLE_WIDTH-1:0] rotated_re,
    output logic signed [SAMPLE_WIDTH-1:0] rotated_im,
    output logic                           rotated_last,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import dpr_pkg::*;

    localparam int AW = TABLE_ADDR_WIDTH;
    localparam logic [AW:0] TBL_N = (AW + 1)'(1) << AW;

    logic [PHASE_WIDTH-1:0] step_reg;
    logic [PHASE_WIDTH-1:0] phase_reg;
    logic [PHASE_WIDTH-1:0] phase_sum;

    logic v0_reg, v1_reg, v2_reg, v3_reg;
    logic free0, free1, free2, free3;
    logic in_fire;
    pipe_ctl_t ctl;

    logic signed [SAMPLE_WIDTH-1:0] re0_reg, im0_reg, re1_reg, im1_reg;
    logic                           last0_reg, last1_reg;
    logic [1:0]                     quad0_reg, quad1_reg;
    logic [AW-1:0]                  idx0_reg;

    logic [TRIG_WIDTH-1:0] tbl_a;
    logic [TRIG_WIDTH-1:0] tbl_b;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PHASE_STEP) ? 32'(step_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_PHASE_STEP)
        begin
            step_reg <= PHASE_WIDTH'(pwdata);
        end
    end

    // stage flow: a stage takes a beat when it is empty or its beat moves on
    assign free3        = !v3_reg || !rotated_stall;
    assign free2        = !v2_reg || free3;
    assign free1        = !v1_reg || free2;
    assign free0        = !v0_reg || free1;
    assign sample_stall = !free0;
    assign in_fire      = sample_valid && free0;
    assign ctl.s1_load  = free1 && v0_reg;
    assign ctl.s2_load  = free2 && v1_reg;
    assign ctl.s3_load  = free3 && v2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (free0) v0_reg <= sample_valid;
            if (free1) v1_reg <= v0_reg;
            if (free2) v2_reg <= v1_reg;
            if (free3) v3_reg <= v2_reg;
        end
    end

    assign rotated_valid = v3_reg;

    // phase accumulator: advances per accepted beat, clears after a last beat
    assign phase_sum = phase_reg + step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else if (in_fire)
        begin
            phase_reg <= sample_last ? '0 : phase_sum;
        end
    end

    // input register, takes the table index from the current phase
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            re0_reg   <= sample_re;
            im0_reg   <= sample_im;
            last0_reg <= sample_last;
            quad0_reg <= phase_reg[PHASE_WIDTH-1 -: 2];
            idx0_reg  <= phase_reg[PHASE_WIDTH-3 -: AW];
        end
    end

    // payload alongside the table read
    always_ff @(posedge clk)
    begin
        if (ctl.s1_load)
        begin
            re1_reg   <= re0_reg;
            im1_reg   <= im0_reg;
            last1_reg <= last0_reg;
            quad1_reg <= quad0_reg;
        end
    end

    dpr_sine_rom #(
        .TABLE_ADDR_WIDTH (TABLE_ADDR_WIDTH)
    ) u_rom (
        .clk    (clk),
        .rd_en  (ctl.s1_load),
        .addr_a ({1'b0, idx0_reg}),
        .addr_b (TBL_N - {1'b0, idx0_reg}),
        .data_a (tbl_a),
        .data_b (tbl_b)
    );

    dpr_rotate #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_rotate (
        .clk          (clk),
        .ctl          (ctl),
        .tbl_a        (tbl_a),
        .tbl_b        (tbl_b),
        .quad         (quad1_reg),
        .re           (re1_reg),
        .im           (im1_reg),
        .last         (last1_reg),
        .rotated_re   (rotated_re),
        .rotated_im   (rotated_im),
        .rotated_last (rotated_last)
    );

    // checks on pipeline fill and phase update
    `DPR_ASSERT_IMP(a_stall_only_when_full, sample_stall,
                    v0_reg && v1_reg && v2_reg && rotated_valid && rotated_stall)
    `DPR_ASSERT_NXT(a_last_clears_phase, in_fire && sample_last, phase_reg == '0)
    `DPR_ASSERT_NXT(a_phase_advances, in_fire && !sample_last,
                    phase_reg == $past(phase_sum))
    `DPR_ASSERT_NXT(a_phase_holds_idle, !in_fire, $stable(phase_reg))

endmodule
